// ----- hdl/wconv_pkg.sv -----
// Shared types, constants and register codes for the window convolution block.
package wconv_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_KERNEL_W_DEF = 13;
  localparam int MAX_KERNEL_H_DEF = 9;
  localparam int MAX_LINE_DEF     = 1024;

  // Largest output frame height and the width of the row counter.
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 13;

  typedef logic signed [15:0] pix_t;
  typedef logic signed [31:0] word_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_KERNEL_WIDTH  = 2'd2,
    REG_KERNEL_HEIGHT = 2'd3
  } reg_idx_t;

  // Controls that every column cell receives.
  typedef struct packed {
    logic shift;
    logic load_prod;
    logic load_sum;
    logic use_col;
  } cell_ctrl_t;

endpackage

// ----- hdl/window_2d_convolution_top.sv -----
// Top level of the 2D window convolution: counters, coefficients, cell row and sum tree.
//
//   channel   direction  contents
//   s_*       in         tuser: action; tdata: pixel, coef_row, coef_col, coef_value
//   m_*       out        tdata: out_value; tlast: end_of_row; tuser: end_of_frame
//   APB       in/out     image_width, image_height, kernel_width, kernel_height
//
// One item is taken per clock while s_tready is high; a result passes through the product,
// column sum, group sum and final sum registers after its pixel transfer.
// Reset clears counters, coefficients and pipeline valids; the line buffer is not
// cleared, as rows of a frame are written before they are used.
// With m_tready low the four result stages fill, then s_tready falls.
module window_2d_convolution_top #(
  parameter int MAX_KERNEL_W = wconv_pkg::MAX_KERNEL_W_DEF,
  parameter int MAX_KERNEL_H = wconv_pkg::MAX_KERNEL_H_DEF,
  parameter int MAX_LINE     = wconv_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // pixel, coef_row, coef_col, coef_value
  input  logic [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_value
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // end_of_frame
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wconv_pkg::*;

  localparam int LINE_ROWS  = (MAX_KERNEL_H > 1) ? MAX_KERNEL_H - 1 : 1;
  localparam int LINE_SLOTS = MAX_LINE + MAX_KERNEL_W - 1;
  localparam int COL_W      = $clog2(LINE_SLOTS);
  localparam int PW_W       = $clog2(LINE_SLOTS + 1);
  localparam int GROUPS     = (MAX_KERNEL_W + 3) / 4;

  // Configuration registers.
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [3:0]  kernel_width;
  logic [3:0]  kernel_height;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 11'd64;
      image_height  <= 13'd64;
      kernel_width  <= 4'd13;
      kernel_height <= 4'd9;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_IMAGE_WIDTH:   image_width   <= pwdata[10:0];
        REG_IMAGE_HEIGHT:  image_height  <= pwdata[12:0];
        REG_KERNEL_WIDTH:  kernel_width  <= pwdata[3:0];
        REG_KERNEL_HEIGHT: kernel_height <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_IMAGE_WIDTH:   prdata = {21'd0, image_width};
      REG_IMAGE_HEIGHT:  prdata = {19'd0, image_height};
      REG_KERNEL_WIDTH:  prdata = {28'd0, kernel_width};
      REG_KERNEL_HEIGHT: prdata = {28'd0, kernel_height};
      default:           prdata = '0;
    endcase
  end

  // Saturated sizes and padded frame dimensions.
  logic [3:0]      kw_c, kh_c;
  logic [PW_W-1:0] iw_c, pad_w;
  logic [12:0]     ih_c, pad_h;

  always_comb begin
    if (kernel_width == 4'd0) kw_c = 4'd1;
    else if (int'(kernel_width) > MAX_KERNEL_W) kw_c = 4'(MAX_KERNEL_W);
    else kw_c = kernel_width;
    if (kernel_height == 4'd0) kh_c = 4'd1;
    else if (int'(kernel_height) > MAX_KERNEL_H) kh_c = 4'(MAX_KERNEL_H);
    else kh_c = kernel_height;
    if (image_width == 11'd0) iw_c = PW_W'(1);
    else if (int'(image_width) > MAX_LINE) iw_c = PW_W'(MAX_LINE);
    else iw_c = PW_W'(image_width);
    if (image_height == 13'd0) ih_c = 13'd1;
    else if (int'(image_height) > MAX_HEIGHT) ih_c = 13'(MAX_HEIGHT);
    else ih_c = image_height;
  end

  assign pad_w = iw_c + PW_W'(kw_c) - PW_W'(1);
  assign pad_h = ih_c + 13'(kh_c) - 13'd1;

  // Input fields.
  logic        action;
  pix_t        pixel;
  logic [3:0]  coef_row, coef_col;
  word_t       coef_value;

  assign pixel      = s_tdata[15:0];
  assign coef_row   = s_tdata[19:16];
  assign coef_col   = s_tdata[23:20];
  assign coef_value = s_tdata[55:24];
  assign action     = s_tuser[0];

  // Result pipeline handshake.
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;
  logic acc_pix, acc_coef;

  assign ready4   = !v4 || m_tready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;
  assign acc_pix  = s_tvalid && s_tready && action;
  assign acc_coef = s_tvalid && s_tready && !action;

  // Frame position.
  logic [COL_W-1:0]  column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [PW_W-1:0]   c_plus;
  logic [ROW_W-1:0]  r_plus;
  logic              emit, eor, eof;

  assign c_plus = PW_W'(column_count) + PW_W'(1);
  assign r_plus = row_count + 13'd1;
  assign emit   = (r_plus >= 13'(kh_c)) && (c_plus >= PW_W'(kw_c));
  assign eor    = c_plus >= pad_w;
  assign eof    = eor && (r_plus >= pad_h);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (cfg_wr) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (acc_pix) begin
      if (eor) begin
        column_count_next = '0;
        row_count_next    = eof ? '0 : r_plus;
      end else begin
        column_count_next = c_plus[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Line buffer, read one column ahead, with a bypass for a one-column frame.
  pix_t [LINE_ROWS-1:0]    line_rd, line_q, line_wr;
  pix_t [LINE_ROWS-1:0]    byp_data;
  logic                    byp_valid;
  pix_t [MAX_KERNEL_H-1:0] col_new;

  wconv_line_buf #(
    .LANES (LINE_ROWS),
    .DEPTH (LINE_SLOTS),
    .AW    (COL_W)
  ) u_line_buf (
    .clk     (clk),
    .we      (acc_pix),
    .wr_addr (column_count),
    .wr_data (line_wr),
    .rd_addr (column_count_next),
    .rd_data (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= acc_pix && (column_count_next == column_count);
    end
    byp_data <= line_wr;
  end

  assign line_q = byp_valid ? byp_data : line_rd;

  // New column: older rows from the line buffer, the pixel in the newest row.
  always_comb begin
    for (int t = 0; t < MAX_KERNEL_H; t++) begin
      if (t < LINE_ROWS && t + 1 < int'(kh_c)) col_new[t] = line_q[t];
      else if (t + 1 == int'(kh_c)) col_new[t] = pixel;
      else col_new[t] = '0;
    end
    for (int t = 0; t < LINE_ROWS; t++) begin
      if (t + 1 < MAX_KERNEL_H) line_wr[t] = col_new[t + 1];
      else line_wr[t] = pixel;
    end
  end

  // Coefficient store.
  word_t coef_store [MAX_KERNEL_H][MAX_KERNEL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MAX_KERNEL_H; t++) begin
        for (int s = 0; s < MAX_KERNEL_W; s++) begin
          coef_store[t][s] <= '0;
        end
      end
    end else if (acc_coef) begin
      for (int t = 0; t < MAX_KERNEL_H; t++) begin
        for (int s = 0; s < MAX_KERNEL_W; s++) begin
          if (coef_row == 4'(t) && coef_col == 4'(s)) begin
            coef_store[t][s] <= coef_value;
          end
        end
      end
    end
  end

  // Coefficient for each cell, aligned to the right edge of the window.
  word_t [MAX_KERNEL_H-1:0] cell_coef [MAX_KERNEL_W];
  logic  [MAX_KERNEL_H-1:0] row_mask;

  always_comb begin
    for (int i = 0; i < MAX_KERNEL_W; i++) begin
      for (int t = 0; t < MAX_KERNEL_H; t++) begin
        cell_coef[i][t] = '0;
        for (int s = 0; s < MAX_KERNEL_W; s++) begin
          if (i + int'(kw_c) - MAX_KERNEL_W == s) cell_coef[i][t] = coef_store[t][s];
        end
      end
    end
    for (int t = 0; t < MAX_KERNEL_H; t++) begin
      row_mask[t] = t < int'(kh_c);
    end
  end

  // Row of column cells; the new column enters at the right end.
  pix_t [MAX_KERNEL_H-1:0] cell_in  [MAX_KERNEL_W];
  pix_t [MAX_KERNEL_H-1:0] cell_out [MAX_KERNEL_W];
  word_t                   col_sum  [MAX_KERNEL_W];
  cell_ctrl_t              cell_ctrl [MAX_KERNEL_W];

  for (genvar i = 0; i < MAX_KERNEL_W; i++) begin : g_cell
    if (i == MAX_KERNEL_W - 1) begin : g_head
      assign cell_in[i] = col_new;
    end else begin : g_link
      assign cell_in[i] = cell_out[i + 1];
    end

    assign cell_ctrl[i].shift     = acc_pix;
    assign cell_ctrl[i].load_prod = acc_pix;
    assign cell_ctrl[i].load_sum  = ready2 && v1;
    assign cell_ctrl[i].use_col   = i + int'(kw_c) >= MAX_KERNEL_W;

    wconv_cell #(
      .ROWS (MAX_KERNEL_H)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .row_mask (row_mask),
      .col_in   (cell_in[i]),
      .coef     (cell_coef[i]),
      .col_out  (cell_out[i]),
      .col_sum  (col_sum[i])
    );
  end

  // Sum tree over the column sums, with the row and frame marks alongside.
  word_t grp_sum [GROUPS];
  word_t grp_next [GROUPS];
  word_t total, total_next;
  logic  eor1, eof1, eor2, eof2, eor3, eof3, eor4, eof4;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (4 * g + k < MAX_KERNEL_W) grp_next[g] = grp_next[g] + col_sum[4 * g + k];
      end
    end
    total_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total_next = total_next + grp_sum[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= acc_pix && emit;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
    if (acc_pix) begin
      eor1 <= eor;
      eof1 <= eof;
    end
    if (ready2 && v1) begin
      eor2 <= eor1;
      eof2 <= eof1;
    end
    if (ready3 && v2) begin
      grp_sum <= grp_next;
      eor3    <= eor2;
      eof3    <= eof2;
    end
    if (ready4 && v3) begin
      total <= total_next;
      eor4  <= eor3;
      eof4  <= eof3;
    end
  end

  assign m_tvalid   = v4;
  assign m_tdata    = total;
  assign m_tlast    = eor4;
  assign m_tuser[0] = eof4;

  // The frame mark only comes with a row mark.
  a_eof_has_eor: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("end of frame without end of row");

  // Counters stay inside the padded frame.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    PW_W'(column_count) < pad_w)
    else $error("column counter beyond padded width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_count < pad_h)
    else $error("row counter beyond padded height");

  // The column sum stage only fills from the product stage.
  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    $rose(v2) |-> $past(v1))
    else $error("column sum stage filled without products");

endmodule

// ----- hdl/wconv_line_buf.sv -----
// Line buffer memory holding the previous padded rows, one lane per row.
module wconv_line_buf #(
  parameter int LANES = 8,
  parameter int DEPTH = 1036,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   wr_addr,
  input  wconv_pkg::pix_t [LANES-1:0]     wr_data,
  input  logic [AW-1:0]                   rd_addr,
  output wconv_pkg::pix_t [LANES-1:0]     rd_data
);
  import wconv_pkg::*;

  pix_t [LANES-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/wconv_cell.sv -----
// Column cell: one window column, its products and the column sum.
module wconv_cell #(
  parameter int ROWS = 9
) (
  input  logic                           clk,
  input  wconv_pkg::cell_ctrl_t          ctrl,
  input  logic [ROWS-1:0]                row_mask,
  input  wconv_pkg::pix_t [ROWS-1:0]     col_in,
  input  wconv_pkg::word_t [ROWS-1:0]    coef,
  output wconv_pkg::pix_t [ROWS-1:0]     col_out,
  output wconv_pkg::word_t               col_sum
);
  import wconv_pkg::*;

  pix_t [ROWS-1:0]  win;
  word_t [ROWS-1:0] prod;
  word_t [ROWS-1:0] prod_next;
  word_t            sum_next;

  // Products use the column that enters the cell in this transfer.
  always_comb begin
    logic signed [47:0] full;
    full = '0;
    for (int t = 0; t < ROWS; t++) begin
      full = $signed(col_in[t]) * $signed(coef[t]);
      prod_next[t] = (ctrl.use_col && row_mask[t]) ? full[31:0] : '0;
    end
  end

  // Column sum of the registered products.
  always_comb begin
    sum_next = '0;
    for (int t = 0; t < ROWS; t++) begin
      sum_next = sum_next + prod[t];
    end
  end

  // Window column shifts to the left neighbor on each pixel transfer.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      win <= col_in;
    end
    if (ctrl.load_prod) begin
      prod <= prod_next;
    end
    if (ctrl.load_sum) begin
      col_sum <= sum_next;
    end
  end

  assign col_out = win;

endmodule

// ----- test/tb_window_2d_convolution_top.sv -----
// Self-checking testbench for the window convolution block: stream stimulus, prediction, checks.
module tb_window_2d_convolution_top;
  import wconv_pkg::*;

  localparam int KW_MAX      = 13;
  localparam int KH_MAX      = 9;
  localparam int LINE_MAX    = 1024;
  localparam int SLOTS       = LINE_MAX + KW_MAX - 1;
  localparam int PIPE_WAIT   = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_PHASES    = 6;

  typedef struct {
    logic        action;
    logic [15:0] pixel;
    logic [3:0]  coef_row;
    logic [3:0]  coef_col;
    logic [31:0] coef_value;
  } stream_item_t;

  typedef struct {
    logic [31:0] sum;
    logic        eor;
    logic        eof;
  } window_sum_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // pixel, coef_row, coef_col, coef_value
  logic [0:0]  s_tuser;   // action
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // out_value
  logic        m_tlast;   // end_of_row
  logic [0:0]  m_tuser;   // end_of_frame
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  window_2d_convolution_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Stimulus and expectation stores.
  stream_item_t pending_items[$];
  window_sum_t  expected_sums[$];
  int errors = 0;
  int pixels_sent = 0;
  int loads_sent = 0;
  int sums_checked = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic start_hold = 1'b0;

  // Mirror of the block's state.
  logic [31:0] coef_mem [KH_MAX][KW_MAX];
  logic [15:0] line_mem [KH_MAX-1][SLOTS];
  logic [15:0] win_mem  [KH_MAX][KW_MAX];
  int unsigned col_pos, row_pos;
  int unsigned cfg_w, cfg_h, cfg_kw, cfg_kh;

  always #6 clk = ~clk;

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Register writes also restart the frame.
  function automatic void apply_register(reg_idx_t idx, logic [31:0] val);
    case (idx)
      REG_IMAGE_WIDTH:   cfg_w  = 32'(val[10:0]);
      REG_IMAGE_HEIGHT:  cfg_h  = 32'(val[12:0]);
      REG_KERNEL_WIDTH:  cfg_kw = 32'(val[3:0]);
      REG_KERNEL_HEIGHT: cfg_kh = 32'(val[3:0]);
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Applies one accepted item: a coefficient load updates the mirror; a pixel advances the window and queues any sum.
  function automatic void convolve_item(stream_item_t it);
    int unsigned kw, kh, pw, ph, c, r, base;
    logic [15:0] column [KH_MAX];
    logic [31:0] acc;
    window_sum_t res;
    if (!it.action) begin
      if (it.coef_row < KH_MAX && it.coef_col < KW_MAX)
        coef_mem[it.coef_row][it.coef_col] = it.coef_value;
      return;
    end
    kw = clamp(cfg_kw, KW_MAX);
    kh = clamp(cfg_kh, KH_MAX);
    pw = clamp(cfg_w, LINE_MAX) + kw - 1;
    ph = clamp(cfg_h, 4096) + kh - 1;
    c = (col_pos >= SLOTS) ? SLOTS - 1 : col_pos;
    r = row_pos;
    for (int t = 0; t + 1 < kh; t++) column[t] = line_mem[t][c];
    column[kh-1] = it.pixel;
    for (int t = 0; t + 1 < kh; t++) line_mem[t][c] = column[t+1];
    for (int t = 0; t < KH_MAX; t++) begin
      for (int s = 0; s + 1 < KW_MAX; s++) win_mem[t][s] = win_mem[t][s+1];
      win_mem[t][KW_MAX-1] = (t < kh) ? column[t] : 16'd0;
    end
    res.eor = (c + 1 >= pw);
    res.eof = res.eor && (r + 1 >= ph);
    if ((r + 1 >= kh) && (c + 1 >= kw)) begin
      acc = 32'd0;
      base = KW_MAX - kw;
      for (int t = 0; t < kh; t++)
        for (int s = 0; s < kw; s++)
          acc += {{16{win_mem[t][base+s][15]}}, win_mem[t][base+s]} * coef_mem[t][s];
      res.sum = acc;
      expected_sums.push_back(res);
    end
    if (res.eor) begin
      col_pos = 0;
      row_pos = res.eof ? 0 : ((r + 1) & 13'h1FFF);
    end else begin
      col_pos = (c + 1) & 11'h7FF;
    end
  endfunction

  // Driver: moves queued items onto the input stream and predicts each transfer.
  always @(posedge clk) begin
    stream_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        convolve_item('{s_tuser[0], s_tdata[15:0], s_tdata[19:16], s_tdata[23:20],
                        s_tdata[55:24]});
        if (s_tuser[0]) pixels_sent++;
        else loads_sent++;
      end
      if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {it.coef_value, it.coef_col, it.coef_row, it.pixel};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, with a long hold-off counted here on request.
  always @(posedge clk) begin
    int hold_left;
    if (rst) begin
      hold_left = 0;
      m_tready <= 1'b0;
    end else begin
      if (start_hold) hold_left = HOLD_CYCLES;
      else if (hold_left > 0) hold_left--;
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: compares each result transfer with the oldest expected sum.
  always @(posedge clk) begin
    window_sum_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result out_value=%h", m_tdata);
        errors++;
      end else begin
        want = expected_sums.pop_front();
        sums_checked++;
        if (m_tdata !== want.sum) begin
          $error("out_value expected %h got %h", want.sum, m_tdata);
          errors++;
        end
        if (m_tlast !== want.eor) begin
          $error("end_of_row expected %b got %b", want.eor, m_tlast);
          errors++;
        end
        if (m_tuser[0] !== want.eof) begin
          $error("end_of_frame expected %b got %b", want.eof, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Waits until all items are sent, all sums have come and the pipeline has drained.
  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_sums.size() > 0)
      @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    apply_register(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [31:0] w, logic [31:0] h, logic [31:0] kw, logic [31:0] kh);
    drain();
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_IMAGE_HEIGHT, h);
    write_register(REG_KERNEL_WIDTH, kw);
    write_register(REG_KERNEL_HEIGHT, kh);
  endtask

  task automatic push_load(logic [3:0] r, logic [3:0] c, logic [31:0] v);
    pending_items.push_back('{1'b0, 16'($urandom), r, c, v});
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Queues n pixels, with a few coefficient loads mixed in.
  task automatic push_pixels(int n);
    logic [15:0] p;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(15))
        0: p = 16'h8000;
        1: p = 16'h7FFF;
        2: p = 16'h0000;
        3: p = 16'hFFFF;
        default: p = 16'($urandom);
      endcase
      pending_items.push_back('{1'b1, p, 4'($urandom), 4'($urandom), $urandom});
      if ($urandom_range(99) < 3) push_load(4'($urandom), 4'($urandom), pick_coef());
    end
  endtask

  function automatic int frame_pixels();
    int unsigned kw, kh;
    kw = clamp(cfg_kw, KW_MAX);
    kh = clamp(cfg_kh, KH_MAX);
    return int'((clamp(cfg_w, LINE_MAX) + kw - 1) * (clamp(cfg_h, 4096) + kh - 1));
  endfunction

  task automatic set_idling(int phase);
    case (phase * 3 / N_PHASES)
      0: begin tx_idle_pct = 8;  rx_idle_pct = 88; end
      1: begin tx_idle_pct = 88; rx_idle_pct = 8;  end
      default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
    endcase
  endtask

  initial begin
    int n;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (coef_mem[i, j]) coef_mem[i][j] = '0;
    foreach (win_mem[i, j]) win_mem[i][j] = '0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    cfg_w = 64;
    cfg_h = 64;
    cfg_kw = 13;
    cfg_kh = 9;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_idling(0);

    // Directed: extreme and out-of-range coefficient loads, then a small 3x2 frame
    // with a 3x3 kernel and extreme pixels.
    push_load(4'd0, 4'd0, 32'h8000_0000);
    push_load(4'd8, 4'd12, 32'h7FFF_FFFF);
    push_load(4'd9, 4'd0, 32'h1234_5678);
    push_load(4'd15, 4'd15, 32'hFFFF_FFFF);
    push_load(4'd0, 4'd13, 32'h0BAD_0BAD);
    configure(3, 2, 3, 3);
    push_load(4'd1, 4'd1, 32'hFFFF_FFFF);
    push_load(4'd0, 4'd2, 32'h7FFF_FFFF);
    push_load(4'd2, 4'd0, 32'h8000_0000);
    for (int i = 0; i < 20; i++) begin
      pending_items.push_back('{1'b1, (i % 3 == 0) ? 16'h8000 :
                                      (i % 3 == 1) ? 16'h7FFF : 16'hFFFF,
                                4'd0, 4'd0, 32'd0});
    end

    // Zero sizes saturate to a 1x1 frame with a 1x1 kernel.
    configure(0, 0, 0, 0);
    push_load(4'd0, 4'd0, pick_coef());
    push_pixels(3);

    // Largest kernel on a small image, with a long receiver hold-off.
    configure(5, 3, 13, 9);
    for (int r = 0; r < KH_MAX; r++)
      for (int c = 0; c < KW_MAX; c++) push_load(4'(r), 4'(c), pick_coef());
    push_pixels(frame_pixels());
    while (s_tready || expected_sums.size() == 0) @(posedge clk);
    start_hold <= 1'b1;
    @(posedge clk);
    start_hold <= 1'b0;

    // Widest line with an oversized kernel width, one row.
    configure(11'h7FF, 1, 15, 1);
    push_pixels(frame_pixels());

    // Tall frame that never finishes, even kernel sizes.
    configure(4, 13'h1FFF, 4, 2);
    push_pixels(60);

    // Random sizes; some frames pause midway until all sums have come.
    for (int ph = 3; ph < N_PHASES; ph++) begin
      configure($urandom_range(6), $urandom_range(3), $urandom_range(15), $urandom_range(15));
      set_idling(ph);
      for (int i = 0; i < 12; i++) push_load(4'($urandom), 4'($urandom), pick_coef());
      n = frame_pixels();
      if ($urandom_range(2) == 0) begin
        push_pixels(n / 2);
        drain();
        push_pixels(n - n / 2);
      end else begin
        push_pixels(n + $urandom_range(n / 2));
      end
    end

    drain();
    $display("Covered %0d pixels and %0d coefficient loads over %0d register settings;",
             pixels_sent, loads_sent, N_PHASES + 2);
    $display("%0d window sums checked, %0d mismatches.", sums_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
